FILE: src/three_axis_moving_average_assert.svh
// assertion macros shared by the moving average modules
`ifndef THREE_AXIS_MOVING_AVERAGE_ASSERT_SVH
`define THREE_AXIS_MOVING_AVERAGE_ASSERT_SVH

`ifndef SYNTHESIS

// property that must hold at every clock edge outside reset
`define TAMA_ASSERT(lbl, clk_i, rstn_i, prop_i, msg_i) \
  lbl: assert property (@(posedge clk_i) disable iff (!rstn_i) (prop_i)) \
    else $error(msg_i);

// condition at one edge implies a consequence at the next edge
`define TAMA_ASSERT_NEXT(lbl, clk_i, rstn_i, ante_i, cons_i, msg_i) \
  lbl: assert property (@(posedge clk_i) disable iff (!rstn_i) (ante_i) |=> (cons_i)) \
    else $error(msg_i);

`else

`define TAMA_ASSERT(lbl, clk_i, rstn_i, prop_i, msg_i)
`define TAMA_ASSERT_NEXT(lbl, clk_i, rstn_i, ante_i, cons_i, msg_i)

`endif

`endif

FILE: src/tama_pkg.sv
package tama_pkg;

  // window length and derived widths
  localparam int WINDOW    = 16;
  localparam int SAMPLE_W  = 16;
  localparam int SLOT_W    = (WINDOW > 1) ? $clog2(WINDOW) : 1;
  localparam int CNT_W     = $clog2(WINDOW + 1);
  localparam int SUM_W     = SAMPLE_W + SLOT_W;
  localparam int DIV_CNT_W = $clog2(SUM_W + 1);
  localparam int AXIS_W    = 2;

  // axis codes
  localparam logic [AXIS_W-1:0] AXIS_X = 2'd0;
  localparam logic [AXIS_W-1:0] AXIS_Y = 2'd1;
  localparam logic [AXIS_W-1:0] AXIS_Z = 2'd2;

  typedef logic signed [SAMPLE_W-1:0] sample_t;
  typedef logic signed [SUM_W-1:0]    sum_t;

  // commands from the controller to the datapath
  typedef struct packed {
    logic              accept;
    logic              update;
    logic              div_start;
    logic [AXIS_W-1:0] axis;
    logic              div_store;
    logic              out_load;
  } ctrl_cmd_t;

  // status from the datapath to the controller
  typedef struct packed {
    logic div_done;
  } dp_status_t;

endpackage

FILE: src/tama_ram.sv
module tama_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 16,
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [WIDTH-1:0]  wdata,
  input  logic [ADDR_W-1:0] raddr,
  output logic [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // single write port, registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: src/tama_div.sv
module tama_div (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  input  logic [tama_pkg::SUM_W-1:0]    dividend,
  input  logic [tama_pkg::CNT_W-1:0]    divisor,
  output logic [tama_pkg::SUM_W-1:0]    quotient,
  output logic                          done
);

  logic                              busy_r, busy_nxt;
  logic                              done_r, done_nxt;
  logic [tama_pkg::DIV_CNT_W-1:0]    cnt_r, cnt_nxt;
  logic [tama_pkg::SUM_W-1:0]        quot_r, quot_nxt;
  logic [tama_pkg::CNT_W-1:0]        rem_r, rem_nxt;
  logic [tama_pkg::CNT_W:0]          rem_shift;
  logic [tama_pkg::CNT_W:0]          rem_diff;
  logic                              q_bit;

  // one restoring step: shift in the next dividend bit and try the subtract
  assign rem_shift = {rem_r, quot_r[tama_pkg::SUM_W-1]};
  assign rem_diff  = rem_shift - {1'b0, divisor};
  assign q_bit     = (rem_shift >= {1'b0, divisor});

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    quot_nxt = quot_r;
    rem_nxt  = rem_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = tama_pkg::DIV_CNT_W'(tama_pkg::SUM_W);
      quot_nxt = dividend;
      rem_nxt  = '0;
    end else if (busy_r) begin
      quot_nxt = {quot_r[tama_pkg::SUM_W-2:0], q_bit};
      rem_nxt  = q_bit ? rem_diff[tama_pkg::CNT_W-1:0] : rem_shift[tama_pkg::CNT_W-1:0];
      cnt_nxt  = cnt_r - 1'b1;
      if (cnt_r == tama_pkg::DIV_CNT_W'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  // working registers
  always_ff @(posedge clk) begin
    quot_r <= quot_nxt;
    rem_r  <= rem_nxt;
  end

  assign quotient = quot_r;
  assign done     = done_r;

endmodule

FILE: src/tama_datapath.sv
`include "three_axis_moving_average_assert.svh"

module tama_datapath (
  input  logic                   clk,
  input  logic                   rst_n,
  input  tama_pkg::ctrl_cmd_t    cmd,
  output tama_pkg::dp_status_t   status,
  input  tama_pkg::sample_t      in_sample_x,
  input  tama_pkg::sample_t      in_sample_y,
  input  tama_pkg::sample_t      in_sample_z,
  output tama_pkg::sample_t      out_mean_x,
  output tama_pkg::sample_t      out_mean_y,
  output tama_pkg::sample_t      out_mean_z,
  output logic                   out_window_full
);

  localparam int RAM_W = 3 * tama_pkg::SAMPLE_W;

  tama_pkg::sample_t                 smp_x_r, smp_y_r, smp_z_r;
  tama_pkg::sum_t                    sum_x_r, sum_y_r, sum_z_r;
  tama_pkg::sum_t                    sum_x_nxt, sum_y_nxt, sum_z_nxt;
  logic [tama_pkg::SLOT_W-1:0]       slot_r, slot_nxt;
  logic [tama_pkg::CNT_W-1:0]        count_r, count_nxt;
  logic                              full;
  logic [RAM_W-1:0]                  ram_rdata;
  logic [RAM_W-1:0]                  ram_wdata;
  tama_pkg::sample_t                 old_x, old_y, old_z;
  tama_pkg::sum_t                    sel_sum;
  logic [tama_pkg::SUM_W-1:0]        sel_mag;
  logic                              neg_r;
  logic [tama_pkg::SUM_W-1:0]        quot;
  logic                              quot_done;
  logic [tama_pkg::SUM_W-1:0]        signed_quot;
  tama_pkg::sample_t                 mean_x_r, mean_y_r, mean_z_r;
  tama_pkg::sample_t                 out_x_r, out_y_r, out_z_r;
  logic                              out_full_r;

  assign full = (count_r == tama_pkg::CNT_W'(tama_pkg::WINDOW));

  // capture the incoming triple
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      smp_x_r <= in_sample_x;
      smp_y_r <= in_sample_y;
      smp_z_r <= in_sample_z;
    end
  end

  // sample ring, all three axes side by side
  assign ram_wdata = {smp_x_r, smp_y_r, smp_z_r};

  tama_ram #(
    .WIDTH (RAM_W),
    .DEPTH (tama_pkg::WINDOW)
  ) u_ram (
    .clk   (clk),
    .we    (cmd.update),
    .waddr (slot_r),
    .wdata (ram_wdata),
    .raddr (slot_r),
    .rdata (ram_rdata)
  );

  assign old_x = ram_rdata[3*tama_pkg::SAMPLE_W-1:2*tama_pkg::SAMPLE_W];
  assign old_y = ram_rdata[2*tama_pkg::SAMPLE_W-1:tama_pkg::SAMPLE_W];
  assign old_z = ram_rdata[tama_pkg::SAMPLE_W-1:0];

  // running sums: add the new sample, drop the overwritten one once full
  always_comb begin
    sum_x_nxt = sum_x_r + {{(tama_pkg::SUM_W-tama_pkg::SAMPLE_W){smp_x_r[tama_pkg::SAMPLE_W-1]}},
                           smp_x_r};
    sum_y_nxt = sum_y_r + {{(tama_pkg::SUM_W-tama_pkg::SAMPLE_W){smp_y_r[tama_pkg::SAMPLE_W-1]}},
                           smp_y_r};
    sum_z_nxt = sum_z_r + {{(tama_pkg::SUM_W-tama_pkg::SAMPLE_W){smp_z_r[tama_pkg::SAMPLE_W-1]}},
                           smp_z_r};
    if (full) begin
      sum_x_nxt = sum_x_nxt - {{(tama_pkg::SUM_W-tama_pkg::SAMPLE_W){old_x[tama_pkg::SAMPLE_W-1]}},
                               old_x};
      sum_y_nxt = sum_y_nxt - {{(tama_pkg::SUM_W-tama_pkg::SAMPLE_W){old_y[tama_pkg::SAMPLE_W-1]}},
                               old_y};
      sum_z_nxt = sum_z_nxt - {{(tama_pkg::SUM_W-tama_pkg::SAMPLE_W){old_z[tama_pkg::SAMPLE_W-1]}},
                               old_z};
    end
  end

  // write position wraps, fill count saturates
  always_comb begin
    slot_nxt  = (slot_r == tama_pkg::SLOT_W'(tama_pkg::WINDOW - 1)) ? '0 : slot_r + 1'b1;
    count_nxt = full ? count_r : count_r + 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sum_x_r <= '0;
      sum_y_r <= '0;
      sum_z_r <= '0;
      slot_r  <= '0;
      count_r <= '0;
    end else if (cmd.update) begin
      sum_x_r <= sum_x_nxt;
      sum_y_r <= sum_y_nxt;
      sum_z_r <= sum_z_nxt;
      slot_r  <= slot_nxt;
      count_r <= count_nxt;
    end
  end

  // divider operand: magnitude of the chosen axis sum
  always_comb begin
    unique case (cmd.axis)
      tama_pkg::AXIS_X: sel_sum = sum_x_r;
      tama_pkg::AXIS_Y: sel_sum = sum_y_r;
      default:          sel_sum = sum_z_r;
    endcase
    sel_mag = sel_sum[tama_pkg::SUM_W-1] ? (~sel_sum + 1'b1) : sel_sum;
  end

  always_ff @(posedge clk) begin
    if (cmd.div_start) begin
      neg_r <= sel_sum[tama_pkg::SUM_W-1];
    end
  end

  tama_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.div_start),
    .dividend (sel_mag),
    .divisor  (count_r),
    .quotient (quot),
    .done     (quot_done)
  );

  assign status.div_done = quot_done;

  // restore the sign, which truncates toward zero
  assign signed_quot = neg_r ? (~quot + 1'b1) : quot;

  always_ff @(posedge clk) begin
    if (cmd.div_store) begin
      unique case (cmd.axis)
        tama_pkg::AXIS_X: mean_x_r <= signed_quot[tama_pkg::SAMPLE_W-1:0];
        tama_pkg::AXIS_Y: mean_y_r <= signed_quot[tama_pkg::SAMPLE_W-1:0];
        default:          mean_z_r <= signed_quot[tama_pkg::SAMPLE_W-1:0];
      endcase
    end
  end

  // output register, frees the working registers for the next item
  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_x_r    <= mean_x_r;
      out_y_r    <= mean_y_r;
      out_z_r    <= mean_z_r;
      out_full_r <= full;
    end
  end

  assign out_mean_x      = out_x_r;
  assign out_mean_y      = out_y_r;
  assign out_mean_z      = out_z_r;
  assign out_window_full = out_full_r;

  // fill count never passes the window length
  `TAMA_ASSERT(a_count_bound, clk, rst_n, count_r <= tama_pkg::CNT_W'(tama_pkg::WINDOW), "fill count beyond window")
  // during the partial window the write position equals the fill count
  `TAMA_ASSERT(a_partial_slot, clk, rst_n, full || (slot_r == tama_pkg::SLOT_W'(count_r)), "write position out of step with fill count")

endmodule

FILE: src/tama_ctrl.sv
`include "three_axis_moving_average_assert.svh"

module tama_ctrl (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_stall,
  output logic                   out_valid,
  input  logic                   out_stall,
  output tama_pkg::ctrl_cmd_t    cmd,
  input  tama_pkg::dp_status_t   status
);

  localparam logic [2:0] S_IDLE     = 3'd0;
  localparam logic [2:0] S_READ     = 3'd1;
  localparam logic [2:0] S_DIV_GO   = 3'd2;
  localparam logic [2:0] S_DIV_WAIT = 3'd3;
  localparam logic [2:0] S_FINISH   = 3'd4;

  logic [2:0]                    state_r, state_nxt;
  logic [tama_pkg::AXIS_W-1:0]   axis_r, axis_nxt;
  logic                          out_valid_r, out_valid_nxt;
  logic                          out_free;

  assign in_stall = (state_r != S_IDLE);
  assign out_free = !out_valid_r || !out_stall;

  // sequencer: read old entry, update sums, divide three axes, hand over
  always_comb begin
    state_nxt     = state_r;
    axis_nxt      = axis_r;
    cmd           = '0;
    cmd.axis      = axis_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.accept = 1'b1;
          state_nxt  = S_READ;
        end
      end
      S_READ: begin
        cmd.update = 1'b1;
        axis_nxt   = tama_pkg::AXIS_X;
        state_nxt  = S_DIV_GO;
      end
      S_DIV_GO: begin
        cmd.div_start = 1'b1;
        state_nxt     = S_DIV_WAIT;
      end
      S_DIV_WAIT: begin
        if (status.div_done) begin
          cmd.div_store = 1'b1;
          if (axis_r == tama_pkg::AXIS_Z) begin
            state_nxt = S_FINISH;
          end else begin
            axis_nxt  = axis_r + 1'b1;
            state_nxt = S_DIV_GO;
          end
        end
      end
      S_FINISH: begin
        if (out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // result valid flag
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      axis_r      <= tama_pkg::AXIS_X;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      axis_r      <= axis_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

  // an accepted item goes straight to the ring read
  `TAMA_ASSERT_NEXT(a_accept_read, clk, rst_n, in_valid && !in_stall, state_r == S_READ, "accepted item did not start")
  // a finished result waits while the output register is still taken
  `TAMA_ASSERT_NEXT(a_finish_hold, clk, rst_n, (state_r == S_FINISH) && out_valid_r && out_stall, state_r == S_FINISH, "result dropped while output blocked")
  // divider only finishes while the sequencer waits for it
  `TAMA_ASSERT(a_done_wait, clk, rst_n, !status.div_done || (state_r == S_DIV_WAIT), "divider finished outside wait state")

endmodule

FILE: src/three_axis_moving_average.sv
// an item is taken only in idle; in_stall holds off the next one until the result is loaded
// into the output register; the shared bit-serial divider, one quotient bit per cycle,
//   serves each of the three axes in turn and sets the pace
// a finished result waits in the output register while the next item is taken
// reset: synchronous active-low rst_n clears sums, write position, fill count and control
// the sample ring is not cleared; only written entries are ever read back
module three_axis_moving_average (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  tama_pkg::sample_t   in_sample_x,
  input  tama_pkg::sample_t   in_sample_y,
  input  tama_pkg::sample_t   in_sample_z,
  output logic                out_valid,
  input  logic                out_stall,
  output tama_pkg::sample_t   out_mean_x,
  output tama_pkg::sample_t   out_mean_y,
  output tama_pkg::sample_t   out_mean_z,
  output logic                out_window_full
);

  tama_pkg::ctrl_cmd_t  cmd;
  tama_pkg::dp_status_t status;

  // sequencer
  tama_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd),
    .status    (status)
  );

  // sums, ring, divider and output register
  tama_datapath u_datapath (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .status          (status),
    .in_sample_x     (in_sample_x),
    .in_sample_y     (in_sample_y),
    .in_sample_z     (in_sample_z),
    .out_mean_x      (out_mean_x),
    .out_mean_y      (out_mean_y),
    .out_mean_z      (out_mean_z),
    .out_window_full (out_window_full)
  );

endmodule
